/* src/efe_pkg.sv */
// Shared types and byte codes for the escaped byte frame encoder.
package efe_pkg;

	localparam logic [7:0] SYNC_BYTE     = 8'hA5;
	localparam logic [7:0] SYNC_ESC      = 8'hA6;
	localparam logic [7:0] TAIL_BYTE     = 8'h5A;
	localparam logic [7:0] TAIL_ESC      = 8'h5B;
	localparam logic [7:0] ESC_CODE_FLAG = 8'h02;
	localparam logic [7:0] ESC_CODE_SELF = 8'h01;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       frame_start;
		logic       frame_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       burst_last;
	} code_t;

endpackage

/* src/escaped_byte_frame_encoder_unit.sv */
// Frame encoder: preamble, escaped payload and trailer, one byte per cycle unless stalled.
//
// Each accepted item is decoded into a burst register that holds the remaining preamble
// count, up to two escaped payload bytes and the trailer flag; one byte a cycle moves from
// that register into the output register while the output is empty or code_stall is low.
// An item produces one byte for a plain byte, two for an escaped byte, and up to
// PREAMBLE_LEN + 3 for an item that opens a frame, carries an escaped byte and closes it.
// The next item is accepted in the same cycle that the last byte of the current burst
// enters the output register, so the output runs without gaps; an item that produces no
// bytes is taken and dropped. burst_last marks the final byte of each item.
module escaped_byte_frame_encoder_unit #(
	parameter int PREAMBLE_LEN = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  efe_pkg::item_t item,
	output logic           code_valid,
	input  logic           code_stall,
	output efe_pkg::code_t code
);

	localparam int CW = (PREAMBLE_LEN > 0) ? $clog2(PREAMBLE_LEN + 1) : 1;
	localparam logic [CW-1:0] PRE_LOAD = CW'(PREAMBLE_LEN);

	// Burst register: what remains to be sent for the current item.
	logic          busy_s1;
	logic [CW-1:0] pre_cnt_s1;
	logic [1:0]    pay_cnt_s1;
	logic [7:0]    pay0_s1;
	logic [7:0]    pay1_s1;
	logic          trl_s1;

	logic          code_valid_q;
	efe_pkg::code_t code_q;

	// Decode of the incoming item.
	logic [CW-1:0] in_pre;
	logic [1:0]    in_pay_cnt;
	logic [7:0]    in_pay0;
	logic [7:0]    in_pay1;
	logic          in_esc;
	logic          in_work;

	always_comb begin
		in_pre     = item.frame_start ? PRE_LOAD : '0;
		in_pay_cnt = item.byte_valid ? 2'd1 : 2'd0;
		in_pay0    = item.data_byte;
		in_pay1    = efe_pkg::ESC_CODE_SELF;
		in_esc     = 1'b0;
		case (item.data_byte)
			efe_pkg::SYNC_BYTE: begin
				in_pay0 = efe_pkg::SYNC_ESC;
				in_pay1 = efe_pkg::ESC_CODE_FLAG;
				in_esc  = 1'b1;
			end
			efe_pkg::SYNC_ESC: begin
				in_pay0 = efe_pkg::SYNC_ESC;
				in_pay1 = efe_pkg::ESC_CODE_SELF;
				in_esc  = 1'b1;
			end
			efe_pkg::TAIL_BYTE: begin
				in_pay0 = efe_pkg::TAIL_ESC;
				in_pay1 = efe_pkg::ESC_CODE_FLAG;
				in_esc  = 1'b1;
			end
			efe_pkg::TAIL_ESC: begin
				in_pay0 = efe_pkg::TAIL_ESC;
				in_pay1 = efe_pkg::ESC_CODE_SELF;
				in_esc  = 1'b1;
			end
			default: begin
				in_pay0 = item.data_byte;
				in_pay1 = efe_pkg::ESC_CODE_SELF;
				in_esc  = 1'b0;
			end
		endcase
		if (item.byte_valid && in_esc) begin
			in_pay_cnt = 2'd2;
		end
		in_work = (in_pre != '0) || item.byte_valid || item.frame_end;
	end

	// Selection of the next byte out of the burst register.
	logic          advance;
	logic [7:0]    next_byte;
	logic [CW-1:0] pre_nxt;
	logic [1:0]    pay_cnt_nxt;
	logic          trl_nxt;
	logic          burst_done;
	logic          accept;

	always_comb begin
		pre_nxt     = pre_cnt_s1;
		pay_cnt_nxt = pay_cnt_s1;
		trl_nxt     = trl_s1;
		if (pre_cnt_s1 != '0) begin
			next_byte = efe_pkg::SYNC_BYTE;
			pre_nxt   = pre_cnt_s1 - CW'(1);
		end else if (pay_cnt_s1 != 2'd0) begin
			next_byte   = pay0_s1;
			pay_cnt_nxt = pay_cnt_s1 - 2'd1;
		end else begin
			next_byte = efe_pkg::TAIL_BYTE;
			trl_nxt   = 1'b0;
		end
		burst_done = (pre_nxt == '0) && (pay_cnt_nxt == 2'd0) && !trl_nxt;
	end

	assign advance    = busy_s1 && (!code_valid_q || !code_stall);
	assign item_stall = busy_s1 && !(advance && burst_done);
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1    <= 1'b0;
			pre_cnt_s1 <= '0;
			pay_cnt_s1 <= 2'd0;
			trl_s1     <= 1'b0;
		end else if (accept) begin
			busy_s1    <= in_work;
			pre_cnt_s1 <= in_pre;
			pay_cnt_s1 <= in_pay_cnt;
			trl_s1     <= item.frame_end;
		end else if (advance) begin
			busy_s1    <= !burst_done;
			pre_cnt_s1 <= pre_nxt;
			pay_cnt_s1 <= pay_cnt_nxt;
			trl_s1     <= trl_nxt;
		end
	end

	// The second payload byte shifts down once the first has gone out.
	always_ff @(posedge clk) begin
		if (accept) begin
			pay0_s1 <= in_pay0;
			pay1_s1 <= in_pay1;
		end else if (advance && (pre_cnt_s1 == '0) && (pay_cnt_s1 != 2'd0)) begin
			pay0_s1 <= pay1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (advance) begin
			code_valid_q <= 1'b1;
		end else if (!code_stall) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q.out_byte   <= next_byte;
			code_q.burst_last <= burst_done;
		end
	end

	assign code_valid = code_valid_q;
	assign code       = code_q;

endmodule

/* bench/tb_escaped_byte_frame_encoder_unit.sv */
// Self-checking testbench for the escaped byte frame encoder.
`timescale 1ns / 1ps

module tb_escaped_byte_frame_encoder_unit;

	localparam int PREAMBLE_LEN = 8;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 32;

	logic           clk;
	logic           arst_n;
	logic           item_valid;
	logic           item_stall;
	efe_pkg::item_t item;
	logic           code_valid;
	logic           code_stall;
	efe_pkg::code_t code;

	efe_pkg::code_t expected_codes[$];
	int             error_count = 0;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             quiet_cycles;

	escaped_byte_frame_encoder_unit #(
		.PREAMBLE_LEN(PREAMBLE_LEN)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code      (code)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		$display("mismatch at %0t: %s expected %02h got %02h", $realtime, what, want, got);
		error_count++;
	endtask

	// Builds the line bytes one item puts out: preamble, escaped payload, trailer.
	task automatic queue_line_bytes(input efe_pkg::item_t it);
		logic [7:0]     line_bytes[$];
		efe_pkg::code_t c;
		if (it.frame_start) begin
			repeat (PREAMBLE_LEN) line_bytes.push_back(efe_pkg::SYNC_BYTE);
		end
		if (it.byte_valid) begin
			case (it.data_byte)
				efe_pkg::SYNC_BYTE: begin
					line_bytes.push_back(efe_pkg::SYNC_ESC);
					line_bytes.push_back(efe_pkg::ESC_CODE_FLAG);
				end
				efe_pkg::SYNC_ESC: begin
					line_bytes.push_back(efe_pkg::SYNC_ESC);
					line_bytes.push_back(efe_pkg::ESC_CODE_SELF);
				end
				efe_pkg::TAIL_BYTE: begin
					line_bytes.push_back(efe_pkg::TAIL_ESC);
					line_bytes.push_back(efe_pkg::ESC_CODE_FLAG);
				end
				efe_pkg::TAIL_ESC: begin
					line_bytes.push_back(efe_pkg::TAIL_ESC);
					line_bytes.push_back(efe_pkg::ESC_CODE_SELF);
				end
				default: line_bytes.push_back(it.data_byte);
			endcase
		end
		if (it.frame_end) begin
			line_bytes.push_back(efe_pkg::TAIL_BYTE);
		end
		foreach (line_bytes[i]) begin
			c.out_byte   = line_bytes[i];
			c.burst_last = (i == line_bytes.size() - 1);
			expected_codes.push_back(c);
		end
	endtask

	// Valid stays high after a transfer; the next call either keeps it up with a new
	// item or first lowers it while idling, so each falling edge carries one update.
	task automatic send_item(input efe_pkg::item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		queue_line_bytes(it);
	endtask

	function automatic efe_pkg::item_t make_item(input logic [7:0] data, input logic valid,
			input logic start, input logic stop);
		efe_pkg::item_t it;
		it.data_byte   = data;
		it.byte_valid  = valid;
		it.frame_start = start;
		it.frame_end   = stop;
		return it;
	endfunction

	function automatic logic [7:0] pick_payload_byte();
		case ($urandom_range(7))
			0:       return efe_pkg::SYNC_BYTE;
			1:       return efe_pkg::SYNC_ESC;
			2:       return efe_pkg::TAIL_BYTE;
			3:       return efe_pkg::TAIL_ESC;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic test_escape_codes();
		logic [7:0] plain_bytes[8] = '{8'h00, 8'hFF, 8'hA4, 8'hA7, 8'h59, 8'h5C,
			efe_pkg::ESC_CODE_SELF, efe_pkg::ESC_CODE_FLAG};
		send_item(make_item(efe_pkg::SYNC_BYTE, 1'b1, 1'b0, 1'b0));
		send_item(make_item(efe_pkg::SYNC_ESC, 1'b1, 1'b0, 1'b0));
		send_item(make_item(efe_pkg::TAIL_BYTE, 1'b1, 1'b0, 1'b0));
		send_item(make_item(efe_pkg::TAIL_ESC, 1'b1, 1'b0, 1'b0));
		foreach (plain_bytes[i]) send_item(make_item(plain_bytes[i], 1'b1, 1'b0, 1'b0));
	endtask

	task automatic test_frame_marks();
		// An item with nothing in it is taken and puts nothing out, whatever its data.
		send_item(make_item(efe_pkg::SYNC_BYTE, 1'b0, 1'b0, 1'b0));
		send_item(make_item(8'hFF, 1'b0, 1'b1, 1'b1));
		send_item(make_item(efe_pkg::SYNC_BYTE, 1'b1, 1'b1, 1'b1));
		send_item(make_item(efe_pkg::TAIL_BYTE, 1'b1, 1'b1, 1'b0));
		send_item(make_item(8'h00, 1'b1, 1'b0, 1'b1));
		send_item(make_item(efe_pkg::TAIL_ESC, 1'b0, 1'b1, 1'b0));
		send_item(make_item(efe_pkg::SYNC_ESC, 1'b0, 1'b0, 1'b1));
		send_item(make_item(8'h00, 1'b1, 1'b1, 1'b1));
		send_item(make_item(8'hFF, 1'b0, 1'b0, 1'b0));
		send_item(make_item(efe_pkg::TAIL_BYTE, 1'b1, 1'b0, 1'b1));
	endtask

	// Mostly whole frames with random payload, plus some items with random marks.
	task automatic test_random_frames(input int target);
		int             sent;
		int             frame_len;
		efe_pkg::item_t it;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(99) < 15) begin
				it = efe_pkg::item_t'(11'($urandom));
				send_item(it);
				if (it.byte_valid || it.frame_start || it.frame_end) sent++;
			end else begin
				frame_len = $urandom_range(0, 6);
				if (frame_len == 0) begin
					send_item(make_item(8'($urandom), 1'b0, 1'b1, 1'b1));
					sent++;
				end else begin
					for (int k = 0; k < frame_len; k++) begin
						send_item(make_item(pick_payload_byte(), $urandom_range(9) != 0,
							k == 0, k == frame_len - 1));
						sent++;
					end
				end
			end
		end
	endtask

	always @(negedge clk) begin
		code_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		efe_pkg::code_t want;
		if (arst_n && code_valid && !code_stall) begin
			if (expected_codes.size() == 0) begin
				report_mismatch("unexpected out_byte", 8'h00, code.out_byte);
			end else begin
				want = expected_codes.pop_front();
				if (code.out_byte !== want.out_byte)
					report_mismatch("out_byte", want.out_byte, code.out_byte);
				if (code.burst_last !== want.burst_last)
					report_mismatch("burst_last", 8'(want.burst_last), 8'(code.burst_last));
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (code_valid && !code_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		send_idle_pct = 33;
		recv_idle_pct = 79;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_escape_codes();
		test_frame_marks();
		test_random_frames(100);
		send_idle_pct = 79;
		recv_idle_pct = 33;
		test_random_frames(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(100);

		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/efe_pkg.sv
src/escaped_byte_frame_encoder_unit.sv
bench/tb_escaped_byte_frame_encoder_unit.sv
